FILE: rtl/byte_alu_with_flags_defines.svh
// assertion macros for the byte alu
`ifndef BYTE_ALU_WITH_FLAGS_DEFINES_SVH
`define BYTE_ALU_WITH_FLAGS_DEFINES_SVH
`ifndef SYNTHESIS
`define BALU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("byte alu assertion failed");
`define BALU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("byte alu assertion failed during reset");
`else
`define BALU_ASSERT(label, prop)
`define BALU_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: rtl/balu_pkg.sv
// shared operation codes and pipeline transaction type for the byte alu
package balu_pkg;

  localparam int DIV_STEPS = 8;

  localparam logic [4:0] MODE_OR     = 5'd0;
  localparam logic [4:0] MODE_AND    = 5'd1;
  localparam logic [4:0] MODE_INH    = 5'd2;
  localparam logic [4:0] MODE_IMP    = 5'd3;
  localparam logic [4:0] MODE_XOR    = 5'd4;
  localparam logic [4:0] MODE_NOR    = 5'd5;
  localparam logic [4:0] MODE_XNOR   = 5'd6;
  localparam logic [4:0] MODE_NAND   = 5'd7;
  localparam logic [4:0] MODE_LSH    = 5'd8;
  localparam logic [4:0] MODE_RSH    = 5'd9;
  localparam logic [4:0] MODE_ROL    = 5'd10;
  localparam logic [4:0] MODE_ROR    = 5'd11;
  localparam logic [4:0] MODE_ADD    = 5'd12;
  localparam logic [4:0] MODE_SUB    = 5'd13;
  localparam logic [4:0] MODE_MUL    = 5'd14;
  localparam logic [4:0] MODE_DIV    = 5'd15;
  localparam logic [4:0] MODE_INC    = 5'd16;
  localparam logic [4:0] MODE_DEC    = 5'd17;
  localparam logic [4:0] MODE_NOT    = 5'd18;
  localparam logic [4:0] MODE_ZERO   = 5'd19;
  localparam logic [4:0] MODE_REV    = 5'd20;
  localparam logic [4:0] MODE_POPCNT = 5'd21;
  localparam logic [4:0] MODE_CLZ    = 5'd22;
  localparam logic [4:0] MODE_CTZ    = 5'd23;

  typedef struct packed {
    logic       is_div;
    logic [7:0] result_a;
    logic [7:0] result_b;
    logic       zero_flag;
    logic       carry_flag;
    logic       parity_flag;
    logic       error_flag;
    logic [7:0] rem;
    logic [7:0] quot_dnd;
    logic [7:0] divisor;
  } balu_item_t;

endpackage

FILE: rtl/balu_front.sv
// decode stage: all operations but the divide steps, registered
module balu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4:0]          mode,
  input  logic [7:0]          operand_a,
  input  logic [7:0]          operand_b,
  output logic                out_valid,
  input  logic                out_ready,
  output balu_pkg::balu_item_t item
);
  import balu_pkg::*;

  balu_item_t item_next;
  logic [8:0]  add_sum;
  logic [8:0]  sub_diff;
  logic [15:0] prod;
  logic [15:0] lsh_w;
  logic [15:0] rsh_w;
  logic [15:0] rol_w;
  logic [15:0] ror_w;
  logic [7:0]  rev_v;
  logic [3:0]  pop_v;
  logic [3:0]  clz_v;
  logic [3:0]  ctz_v;
  logic [7:0]  ra;
  logic [7:0]  rb;
  logic        zf;
  logic        cf;
  logic        pf;
  logic        ef;
  logic        dflt;
  logic        is_div;

  assign add_sum  = {1'b0, operand_a} + {1'b0, operand_b};
  assign sub_diff = {1'b0, operand_a} - {1'b0, operand_b};
  assign prod     = {8'h00, operand_a} * {8'h00, operand_b};
  assign lsh_w    = {8'h00, operand_a} << operand_b[2:0];
  assign rsh_w    = {operand_a, 8'h00} >> operand_b[2:0];
  assign rol_w    = {operand_a, operand_a} << operand_b[2:0];
  assign ror_w    = {operand_a, operand_a} >> operand_b[2:0];

  always_comb begin
    rev_v = '0;
    pop_v = '0;
    clz_v = 4'd8;
    ctz_v = 4'd8;
    for (int i = 0; i < 8; i++) begin
      rev_v[i] = operand_a[7 - i];
      pop_v    = pop_v + {3'b000, operand_a[i]};
      if (operand_a[i]) begin
        clz_v = 4'(7 - i);
      end
    end
    for (int i = 7; i >= 0; i--) begin
      if (operand_a[i]) begin
        ctz_v = 4'(i);
      end
    end
  end

  always_comb begin
    ra     = operand_a;
    rb     = operand_b;
    zf     = 1'b0;
    cf     = 1'b0;
    pf     = 1'b0;
    ef     = 1'b0;
    dflt   = 1'b0;
    is_div = 1'b0;
    case (mode)
      MODE_OR: begin
        ra = operand_a | operand_b; dflt = 1'b1;
      end
      MODE_AND: begin
        ra = operand_a & operand_b; dflt = 1'b1;
      end
      MODE_INH: begin
        ra = ~operand_a & operand_b; dflt = 1'b1;
      end
      MODE_IMP: begin
        ra = operand_a | ~operand_b; dflt = 1'b1;
      end
      MODE_XOR: begin
        ra = operand_a ^ operand_b; dflt = 1'b1;
      end
      MODE_NOR: begin
        ra = ~(operand_a | operand_b); dflt = 1'b1;
      end
      MODE_XNOR: begin
        ra = ~(operand_a ^ operand_b); dflt = 1'b1;
      end
      MODE_NAND: begin
        ra = ~(operand_a & operand_b); dflt = 1'b1;
      end
      MODE_LSH, MODE_RSH: begin
        if (operand_b == 8'd0) begin
          dflt = 1'b1;
        end else if (operand_b > 8'd8) begin
          ra = 8'h00; zf = 1'b1; ef = 1'b1;
        end else if (operand_b == 8'd8) begin
          ra = 8'h00; zf = 1'b1; ef = 1'b1;
          cf = (mode == MODE_LSH) ? operand_a[0] : operand_a[7];
        end else begin
          if (mode == MODE_LSH) begin
            ra = lsh_w[7:0];
            cf = lsh_w[8];
          end else begin
            ra = rsh_w[15:8];
            cf = rsh_w[7];
          end
          zf = (ra == 8'h00);
          pf = ra[0];
        end
      end
      MODE_ROL: begin
        ra = rol_w[15:8]; dflt = 1'b1;
      end
      MODE_ROR: begin
        ra = ror_w[7:0]; dflt = 1'b1;
      end
      MODE_ADD: begin
        ra = add_sum[7:0]; cf = add_sum[8];
        zf = (ra == 8'h00); pf = ra[0];
      end
      MODE_SUB: begin
        ra = sub_diff[7:0]; cf = sub_diff[8];
        zf = (ra == 8'h00); pf = ra[0];
      end
      MODE_MUL: begin
        ra = prod[15:8]; rb = prod[7:0];
        zf = (prod == 16'h0000); cf = (ra != 8'h00); pf = rb[0];
      end
      MODE_DIV: begin
        if (operand_b != 8'd0) begin
          is_div = 1'b1;
        end else begin
          ra = 8'hFF; cf = 1'b1; pf = 1'b1; ef = 1'b1;
        end
      end
      MODE_INC: begin
        if (operand_a == 8'hFF) begin
          ra = 8'h00; cf = 1'b1; zf = 1'b1;
        end else begin
          ra = operand_a + 8'd1; pf = ra[0];
        end
      end
      MODE_DEC: begin
        if (operand_a == 8'h00) begin
          ra = 8'hFF; cf = 1'b1; pf = 1'b1;
        end else begin
          ra = operand_a - 8'd1; zf = (ra == 8'h00); pf = ra[0];
        end
      end
      MODE_NOT: begin
        ra = ~operand_a; zf = (ra == 8'h00); pf = ra[0];
      end
      MODE_ZERO: begin
        ra = 8'h00; zf = 1'b1;
      end
      MODE_REV: begin
        ra = rev_v; zf = (ra == 8'h00); pf = ra[0];
      end
      MODE_POPCNT: begin
        ra = {4'h0, pop_v}; zf = (ra == 8'h00); pf = ra[0];
      end
      MODE_CLZ: begin
        ra = {4'h0, clz_v}; zf = (ra == 8'h00); pf = ra[0];
      end
      MODE_CTZ: begin
        ra = {4'h0, ctz_v}; zf = (ra == 8'h00); pf = ra[0];
      end
      default: begin
        dflt = 1'b1;
      end
    endcase
    if (dflt) begin
      zf = (ra == 8'h00);
      pf = ra[0];
      cf = 1'b0;
      ef = 1'b0;
    end
    item_next.is_div      = is_div;
    item_next.result_a    = ra;
    item_next.result_b    = rb;
    item_next.zero_flag   = zf;
    item_next.carry_flag  = cf;
    item_next.parity_flag = pf;
    item_next.error_flag  = ef;
    item_next.rem         = 8'h00;
    item_next.quot_dnd    = operand_a;
    item_next.divisor     = operand_b;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

FILE: rtl/balu_div_cell.sv
// one restoring divide step cell, passes other transactions through
module balu_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  balu_pkg::balu_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output balu_pkg::balu_item_t out_item
);
  import balu_pkg::*;

  balu_item_t item_next;
  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  assign trial = {in_item.rem, in_item.quot_dnd[7]};
  assign diff  = trial - {1'b0, in_item.divisor};
  assign fits  = (trial >= {1'b0, in_item.divisor});

  always_comb begin
    item_next = in_item;
    if (in_item.is_div) begin
      item_next.rem      = fits ? diff[7:0] : trial[7:0];
      item_next.quot_dnd = {in_item.quot_dnd[6:0], fits};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: rtl/byte_alu_with_flags.sv
// a transaction passes the registered front stage, the eight divide cells and the output register
// throughput: one transaction per cycle while the output is not stalled, through the eight-cell divide chain
// every stage has its own valid bit, so bubbles close up under output stall
// reset clears all stage valid bits and the output valid; data is not reset
module byte_alu_with_flags (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] mode,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] result_a,
  output logic [7:0] result_b,
  output logic       zero_flag,
  output logic       carry_flag,
  output logic       parity_flag,
  output logic       error_flag
);
  import balu_pkg::*;
  `include "byte_alu_with_flags_defines.svh"

  logic       stage_valid [DIV_STEPS+1];
  logic       stage_ready [DIV_STEPS+1];
  balu_item_t stage_item  [DIV_STEPS+1];
  balu_item_t last;
  logic       load_ready;

  balu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .item      (stage_item[0])
  );

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    balu_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_ready  (stage_ready[k]),
      .in_item   (stage_item[k]),
      .out_valid (stage_valid[k+1]),
      .out_ready (stage_ready[k+1]),
      .out_item  (stage_item[k+1])
    );
  end

  assign last       = stage_item[DIV_STEPS];
  assign load_ready = !out_valid || out_ready;
  assign stage_ready[DIV_STEPS] = load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= stage_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid[DIV_STEPS] && load_ready) begin
      if (last.is_div) begin
        result_a    <= last.quot_dnd;
        result_b    <= last.rem;
        zero_flag   <= (last.quot_dnd == 8'h00);
        carry_flag  <= (last.rem == 8'h00);
        parity_flag <= last.quot_dnd[0];
        error_flag  <= 1'b0;
      end else begin
        result_a    <= last.result_a;
        result_b    <= last.result_b;
        zero_flag   <= last.zero_flag;
        carry_flag  <= last.carry_flag;
        parity_flag <= last.parity_flag;
        error_flag  <= last.error_flag;
      end
    end
  end

  `BALU_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !stage_valid[0])
  `BALU_ASSERT(a_zero_means_zero, out_valid && zero_flag |-> result_a == 8'h00)
  `BALU_ASSERT(a_error_result, out_valid && error_flag |-> result_a == 8'h00 || (result_a == 8'hFF && carry_flag && parity_flag))
  `BALU_ASSERT(a_chain_feeds_output, !$past(stage_valid[DIV_STEPS]) && !$past(out_valid) |-> !out_valid)

endmodule
